### src/sqeb_pkg.sv
// Shared types, constants and the quadrature step table for the encoder bank.
`default_nettype none

package sqeb_pkg;

   localparam int SCAN_ROWS  = 4;
   localparam int GROUPS     = 4;
   localparam int ROW_W      = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
   localparam int VALUE_W    = 8;
   localparam int PHASE_W    = 2;
   localparam int COLS_W     = GROUPS * PHASE_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_FLOOR   = 1'b0;
   localparam logic CSR_IDX_CEILING = 1'b1;

   localparam logic [VALUE_W-1:0] FLOOR_RESET   = 8'h00;
   localparam logic [VALUE_W-1:0] CEILING_RESET = 8'hff;

   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [VALUE_W-1:0] value;
   } enc_state_type;

   typedef enc_state_type [GROUPS-1:0] row_state_type;

   // Quadrature table: old phase in the upper bits, new phase in the lower bits.
   function automatic logic signed [1:0] quad_step(input logic [3:0] key);
      logic signed [1:0] step;
      case (key)
         4'd0:    step = 2'sd0;
         4'd1:    step = -2'sd1;
         4'd2:    step = 2'sd1;
         4'd3:    step = 2'sd0;
         4'd4:    step = 2'sd1;
         4'd5:    step = 2'sd0;
         4'd6:    step = 2'sd0;
         4'd7:    step = -2'sd1;
         4'd8:    step = -2'sd1;
         4'd9:    step = 2'sd0;
         4'd10:   step = 2'sd0;
         4'd11:   step = 2'sd1;
         4'd12:   step = 2'sd0;
         4'd13:   step = 2'sd1;
         4'd14:   step = -2'sd1;
         default: step = 2'sd0;
      endcase
      return step;
   endfunction

   // Low two bits of the row for the result field.
   function automatic logic [1:0] row_to_field(input row_type row);
      logic [ROW_W+1:0] wide;
      wide = {2'b00, row};
      return wide[1:0];
   endfunction

endpackage

`default_nettype wire

### src/sqeb_lane.sv
// One encoder update: table step, subtract, clamp to floor then ceiling.
`default_nettype none

module sqeb_lane (
   input  sqeb_pkg::enc_state_type      old_state,
   input  logic [sqeb_pkg::PHASE_W-1:0] new_phase,
   input  logic [sqeb_pkg::VALUE_W-1:0] floor_val,
   input  logic [sqeb_pkg::VALUE_W-1:0] ceiling_val,
   output sqeb_pkg::enc_state_type      new_state
);
   import sqeb_pkg::*;

   logic signed [1:0]         step;
   logic signed [VALUE_W+1:0] diff;
   logic signed [VALUE_W+1:0] lo_clamped;
   logic signed [VALUE_W+1:0] hi_clamped;

   always_comb begin
      step = quad_step({old_state.phase, new_phase});
      diff = signed'({2'b00, old_state.value}) - (VALUE_W+2)'(step);
      if (diff < signed'({2'b00, floor_val})) begin
         lo_clamped = signed'({2'b00, floor_val});
      end else begin
         lo_clamped = diff;
      end
      if (lo_clamped > signed'({2'b00, ceiling_val})) begin
         hi_clamped = signed'({2'b00, ceiling_val});
      end else begin
         hi_clamped = lo_clamped;
      end
      new_state.phase = new_phase;
      new_state.value = hi_clamped[VALUE_W-1:0];
   end

endmodule

`default_nettype wire

### src/scanned_quadrature_encoder_bank_top.sv
// Usage: scanned quadrature encoder bank, row-wide state memory with read-modify-write.
//
// Request channel (req_valid/req_stall/req_column_levels): one sample of the
// eight column levels for the row currently driven. Column pair k updates
// encoder k*SCAN_ROWS+row. The row counter advances after every request.
// Result channel (rsp_valid/rsp_stall/...): the scanned row and the four new
// encoder values of that row, one result per request, in order.
// Pipeline: an accepted request reads its row from memory into the update stage;
// the update stage then computes the new values and writes them into the output
// register once that register is free, and the result shows as valid.
// Throughput: one request per cycle while req_stall is low; the state of a whole
// row lives in one memory word, so each request costs one read and one write
// of that word. A result waiting under rsp_stall does not block the next request:
// it is read and held in the update stage; only when that stage is full too does
// req_stall rise.
// Reset (synchronous): row counter to zero, all row valid bits cleared so every
// encoder reads as phase zero, value zero; floor 0, ceiling 255.
// CSR: byte address 0 is the floor, 4 the ceiling; write them while idle.
`default_nettype none

module scanned_quadrature_encoder_bank_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sqeb_pkg::COLS_W-1:0]     req_column_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_scanned_row,
   output logic [sqeb_pkg::VALUE_W-1:0]    rsp_value_group0,
   output logic [sqeb_pkg::VALUE_W-1:0]    rsp_value_group1,
   output logic [sqeb_pkg::VALUE_W-1:0]    rsp_value_group2,
   output logic [sqeb_pkg::VALUE_W-1:0]    rsp_value_group3,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sqeb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sqeb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sqeb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import sqeb_pkg::*;

   // configuration
   logic [VALUE_W-1:0] floor_ff, floor_in;
   logic [VALUE_W-1:0] ceiling_ff, ceiling_in;
   logic               csr_write;

   // row counter and update stage
   row_type            row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   row_type            s1_row_ff;
   logic [COLS_W-1:0]  s1_cols_ff;

   // state memory with valid bits and write-to-read forwarding
   row_state_type      mem [SCAN_ROWS];
   row_state_type      mem_q_ff;
   logic [SCAN_ROWS-1:0] row_vld_ff, row_vld_in;
   logic               rdv_ff;
   logic               fwd_ff;
   row_state_type      fwd_data_ff;
   row_state_type      rd_entry;
   row_state_type      wr_data;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_row_ff;
   row_state_type      rsp_data_ff;

   logic               req_accept;
   logic               s1_adv;
   logic               fwd_hit;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_FLOOR:   floor_in   = csr_pwdata[VALUE_W-1:0];
            CSR_IDX_CEILING: ceiling_in = csr_pwdata[VALUE_W-1:0];
            default:         floor_in   = floor_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_FLOOR:   csr_prdata = {{(CSR_DATA_W-VALUE_W){1'b0}}, floor_ff};
         CSR_IDX_CEILING: csr_prdata = {{(CSR_DATA_W-VALUE_W){1'b0}}, ceiling_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= FLOOR_RESET;
         ceiling_ff <= CEILING_RESET;
      end else begin
         floor_ff   <= floor_in;
         ceiling_ff <= ceiling_in;
      end
   end

   // ---------------------------------------------------------------- handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign fwd_hit    = s1_adv && (s1_row_ff == row_ff);

   always_comb begin
      if (row_ff == row_type'(SCAN_ROWS - 1)) begin
         row_in = '0;
      end else begin
         row_in = row_ff + 1'b1;
      end
      if (!req_accept) begin
         row_in = row_ff;
      end
      s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
      row_vld_in  = row_vld_ff;
      if (s1_adv) begin
         row_vld_in[s1_row_ff] = 1'b1;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         row_vld_ff   <= row_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem[s1_row_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mem_q_ff <= mem[row_ff];
      end
   end

   // Capture the row, its valid bit and any same-edge write for the update stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (req_accept) begin
         rdv_ff <= row_vld_ff[row_ff];
         fwd_ff <= fwd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff   <= row_ff;
         s1_cols_ff  <= req_column_levels;
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_entry = fwd_data_ff;
      end else if (rdv_ff) begin
         rd_entry = mem_q_ff;
      end else begin
         rd_entry = '0;
      end
   end

   // ---------------------------------------------------------------- update
   for (genvar k = 0; k < GROUPS; k++) begin : g_lane
      sqeb_lane u_lane (
         .old_state   (rd_entry[k]),
         .new_phase   (s1_cols_ff[PHASE_W*k +: PHASE_W]),
         .floor_val   (floor_ff),
         .ceiling_val (ceiling_ff),
         .new_state   (wr_data[k])
      );
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_row_ff  <= row_to_field(s1_row_ff);
         rsp_data_ff <= wr_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scanned_row  = rsp_row_ff;
   assign rsp_value_group0 = rsp_data_ff[0].value;
   assign rsp_value_group1 = rsp_data_ff[1].value;
   assign rsp_value_group2 = rsp_data_ff[2].value;
   assign rsp_value_group3 = rsp_data_ff[3].value;

endmodule

`default_nettype wire

### src/sqeb_checker.sv
// Port-level checks for the encoder bank and their binding to the top level.
`default_nettype none

module sqeb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_scanned_row,
   input logic [sqeb_pkg::VALUE_W-1:0] rsp_value_group0,
   input logic [sqeb_pkg::VALUE_W-1:0] rsp_value_group3
);
   import sqeb_pkg::*;

   // Nothing left over from before reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // An empty output register always frees the request side.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no result waits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_scanned_row) && $stable(rsp_value_group0)
         && $stable(rsp_value_group3))
      else $error("stalled result changed");

endmodule

bind scanned_quadrature_encoder_bank_top sqeb_checker u_sqeb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_scanned_row  (rsp_scanned_row),
   .rsp_value_group0 (rsp_value_group0),
   .rsp_value_group3 (rsp_value_group3)
);

`default_nettype wire
